// File: hw/rtl/cae_pkg.sv
// ----------------------------------------------------------------------------
// CIDR address exclude: shared package
// Address width, field widths, result kind codes and the mask helpers used by
// the fit unit and the top level.
// ----------------------------------------------------------------------------
package cae_pkg;

    localparam int ADDR_BITS   = 32;
    localparam int PREFIX_BITS = 6;
    localparam int KIND_BITS   = 2;

    typedef logic [ADDR_BITS-1:0]   addr_t;
    typedef logic [ADDR_BITS:0]     addr_ext_t;
    typedef logic [PREFIX_BITS-1:0] prefix_t;
    typedef logic [KIND_BITS-1:0]   kind_t;

    localparam kind_t KIND_PIECE     = 2'd0;
    localparam kind_t KIND_UNCHANGED = 2'd1;
    localparam kind_t KIND_NOTHING   = 2'd2;

    // Result of one test of the shared fit unit.
    typedef struct packed {
        logic fits;    // block of the trial size is aligned and stays in range
        logic at_end;  // block of the current size ends exactly at the limit
    } fit_res_t;

    // Low mask of s ones, s from 0 to ADDR_BITS + 1.
    function automatic addr_ext_t low_mask(input prefix_t s);
        low_mask = ~({(ADDR_BITS + 1){1'b1}} << s);
    endfunction

    // Network mask for a prefix length; lengths above ADDR_BITS are clamped.
    function automatic addr_t net_mask(input prefix_t p);
        prefix_t pc;
        pc = (p > prefix_t'(ADDR_BITS)) ? prefix_t'(ADDR_BITS) : p;
        net_mask = {ADDR_BITS{1'b1}} << (prefix_t'(ADDR_BITS) - pc);
    endfunction

endpackage

// File: hw/rtl/cae_if.sv
// ----------------------------------------------------------------------------
// CIDR address exclude: channel interfaces
// Valid/ready channels for the query (two networks) and the emitted blocks.
// ----------------------------------------------------------------------------
interface cae_query_if;
    logic              valid;
    logic              ready;
    cae_pkg::addr_t    outer_address;
    cae_pkg::prefix_t  outer_prefix;
    cae_pkg::addr_t    inner_address;
    cae_pkg::prefix_t  inner_prefix;

    modport source (output valid, output outer_address, output outer_prefix,
                    output inner_address, output inner_prefix, input ready);
    modport sink   (input valid, input outer_address, input outer_prefix,
                    input inner_address, input inner_prefix, output ready);
endinterface

interface cae_result_if;
    logic              valid;
    logic              ready;
    cae_pkg::addr_t    block_address;
    cae_pkg::prefix_t  block_prefix;
    cae_pkg::kind_t    kind;
    logic              last;

    modport source (output valid, output block_address, output block_prefix,
                    output kind, output last, input ready);
    modport sink   (input valid, input block_address, input block_prefix,
                    input kind, input last, output ready);
endinterface

// File: hw/rtl/cidr_address_exclude_core.sv
// ----------------------------------------------------------------------------
// CIDR address exclude core
// Removes an inner IPv4 network from an outer one and emits the remaining
// aligned CIDR blocks in ascending order, one transfer per block.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  query    in         outer_address, outer_prefix, inner_address, inner_prefix
//  result   out        block_address, block_prefix, kind, last
//
//  A query whose outer network does not hold the inner one, or equals it,
//  gives a single result in the cycle after the transfer. Otherwise the
//  sequencer runs one fit test per cycle, stepping the size up or down,
//  confirming a size after each block and then emitting it. The query
//  is not ready until the last block is loaded; a stalled result holds
//  the sequencer at its emit step.
// ----------------------------------------------------------------------------
module cidr_address_exclude_core (
    input  logic          clk,
    input  logic          rst_n,
    cae_query_if.sink     query,
    cae_result_if.source  result
);
    import cae_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH
    } phase_t;

    phase_t   phase_reg,       phase_next;
    addr_t    cursor_reg,      cursor_next;
    addr_t    limit_reg,       limit_next;
    addr_t    upper_start_reg, upper_start_next;
    addr_t    upper_limit_reg, upper_limit_next;
    logic     has_high_reg,    has_high_next;
    prefix_t  shift_reg,       shift_next;
    logic     known_ok_reg,    known_ok_next;
    logic     out_valid_reg,   out_valid_next;
    addr_t    out_addr_reg,    out_addr_next;
    prefix_t  out_prefix_reg,  out_prefix_next;
    kind_t    out_kind_reg,    out_kind_next;
    logic     out_last_reg,    out_last_next;

    addr_t    om, im, os, oe, is_s, ie;
    logic     contains, same, low_part, high_part;
    logic     out_free;
    logic     accept;
    prefix_t  try_shift;
    fit_res_t fit;
    addr_t    fit_next_cursor;

    // Network bounds of the query.
    assign om   = net_mask(query.outer_prefix);
    assign im   = net_mask(query.inner_prefix);
    assign os   = query.outer_address & om;
    assign oe   = os | ~om;
    assign is_s = query.inner_address & im;
    assign ie   = is_s | ~im;

    assign contains  = (is_s >= os) && (ie <= oe);
    assign same      = (is_s == os) && (ie == oe);
    assign low_part  = (is_s > os);
    assign high_part = (ie < oe);

    assign out_free    = !out_valid_reg || result.ready;
    assign query.ready = (phase_reg == PH_IDLE) && out_free;
    assign accept      = query.valid && query.ready;

    // With a known-good size the unit tries one size larger, otherwise it
    // checks the current size.
    assign try_shift = known_ok_reg ? shift_reg + prefix_t'(1) : shift_reg;

    cae_fit_unit u_fit (
        .cursor      (cursor_reg),
        .limit       (limit_reg),
        .try_shift   (try_shift),
        .cur_shift   (shift_reg),
        .res         (fit),
        .next_cursor (fit_next_cursor)
    );

    always_comb
    begin
        phase_next       = phase_reg;
        cursor_next      = cursor_reg;
        limit_next       = limit_reg;
        upper_start_next = upper_start_reg;
        upper_limit_next = upper_limit_reg;
        has_high_next    = has_high_reg;
        shift_next       = shift_reg;
        known_ok_next    = known_ok_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_addr_next    = out_addr_reg;
        out_prefix_next  = out_prefix_reg;
        out_kind_next    = out_kind_reg;
        out_last_next    = out_last_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (accept)
                begin
                    if (!contains)
                    begin
                        out_valid_next  = 1'b1;
                        out_addr_next   = query.outer_address;
                        out_prefix_next = query.outer_prefix;
                        out_kind_next   = KIND_UNCHANGED;
                        out_last_next   = 1'b1;
                    end
                    else if (same)
                    begin
                        out_valid_next  = 1'b1;
                        out_addr_next   = '0;
                        out_prefix_next = '0;
                        out_kind_next   = KIND_NOTHING;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        upper_start_next = ie + addr_t'(1);
                        upper_limit_next = oe;
                        has_high_next    = high_part;
                        shift_next       = '0;
                        known_ok_next    = 1'b1;
                        if (low_part)
                        begin
                            phase_next  = PH_LOW;
                            cursor_next = os;
                            limit_next  = is_s - addr_t'(1);
                        end
                        else
                        begin
                            phase_next  = PH_HIGH;
                            cursor_next = ie + addr_t'(1);
                            limit_next  = oe;
                        end
                    end
                end
            end
            PH_LOW, PH_HIGH:
            begin
                if (!known_ok_reg)
                begin
                    if (fit.fits)
                        known_ok_next = 1'b1;
                    else
                        shift_next = shift_reg - prefix_t'(1);
                end
                else if (fit.fits)
                begin
                    shift_next = shift_reg + prefix_t'(1);
                end
                else if (out_free)
                begin
                    // Current size is the largest that fits: emit it.
                    out_valid_next  = 1'b1;
                    out_addr_next   = cursor_reg;
                    out_prefix_next = prefix_t'(ADDR_BITS) - shift_reg;
                    out_kind_next   = KIND_PIECE;
                    out_last_next   = fit.at_end &&
                                      ((phase_reg == PH_HIGH) || !has_high_reg);
                    cursor_next     = fit_next_cursor;
                    known_ok_next   = 1'b0;
                    if (fit.at_end)
                    begin
                        if ((phase_reg == PH_LOW) && has_high_reg)
                        begin
                            phase_next    = PH_HIGH;
                            cursor_next   = upper_start_reg;
                            limit_next    = upper_limit_reg;
                            shift_next    = '0;
                            known_ok_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            cursor_reg      <= '0;
            limit_reg       <= '0;
            upper_start_reg <= '0;
            upper_limit_reg <= '0;
            has_high_reg    <= 1'b0;
            shift_reg       <= '0;
            known_ok_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_addr_reg    <= '0;
            out_prefix_reg  <= '0;
            out_kind_reg    <= KIND_PIECE;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            cursor_reg      <= cursor_next;
            limit_reg       <= limit_next;
            upper_start_reg <= upper_start_next;
            upper_limit_reg <= upper_limit_next;
            has_high_reg    <= has_high_next;
            shift_reg       <= shift_next;
            known_ok_reg    <= known_ok_next;
            out_valid_reg   <= out_valid_next;
            out_addr_reg    <= out_addr_next;
            out_prefix_reg  <= out_prefix_next;
            out_kind_reg    <= out_kind_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.block_address = out_addr_reg;
    assign result.block_prefix  = out_prefix_reg;
    assign result.kind          = out_kind_reg;
    assign result.last          = out_last_reg;

`ifndef SYNTHESIS
    // An accepted query either starts the sequencer or yields its single result.
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (phase_reg != PH_IDLE) || result.valid)
        else $error("query transfer produced no work");

    // Results other than pieces always close their item.
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.kind != KIND_PIECE) |-> result.last)
        else $error("marker result without last");

    // The block size never grows past the address width.
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (shift_reg <= prefix_t'(ADDR_BITS)))
        else $error("block size out of range");

    // A piece loaded while covering is aligned to its block size.
    a_piece_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !$past(result.valid && !result.ready) && !$past(accept)
        |-> ((result.block_address & addr_t'(low_mask(prefix_t'(ADDR_BITS)
             - result.block_prefix))) == '0))
        else $error("emitted block is not aligned");
`endif

endmodule

// File: hw/rtl/cae_fit_unit.sv
// ----------------------------------------------------------------------------
// CIDR address exclude: shared fit unit
// Tests whether an aligned block of a trial size fits between the cursor and
// the range limit, and gives the end test and next cursor for the block of
// the current size.
// ----------------------------------------------------------------------------
module cae_fit_unit (
    input  cae_pkg::addr_t    cursor,
    input  cae_pkg::addr_t    limit,
    input  cae_pkg::prefix_t  try_shift,
    input  cae_pkg::prefix_t  cur_shift,
    output cae_pkg::fit_res_t res,
    output cae_pkg::addr_t    next_cursor
);
    import cae_pkg::*;

    addr_ext_t cur_x;
    addr_ext_t lim_x;
    addr_ext_t try_mask;
    addr_ext_t cur_end;

    assign cur_x    = {1'b0, cursor};
    assign lim_x    = {1'b0, limit};
    assign try_mask = low_mask(try_shift);
    assign cur_end  = cur_x | low_mask(cur_shift);

    assign res.fits    = ((cur_x & try_mask) == '0) && ((cur_x | try_mask) <= lim_x);
    assign res.at_end  = (cur_end == lim_x);
    // Only used when the block does not end at the limit, so it fits the width.
    assign next_cursor = addr_t'(cur_end + addr_ext_t'(1));

endmodule
